// File: hw/rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the codebook background model
// Request payloads, codeword box layout, operation and register codes.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // Number of channel bytes carried by a request
  localparam int NUM_CH = 3;

  // Operation codes
  localparam logic [1:0] OP_LEARN = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_DIFF  = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_LEARN_BOUNDS  = 2'd1;
  localparam logic [1:0] REG_LOW_SLACK     = 2'd2;
  localparam logic [1:0] REG_HIGH_SLACK    = 2'd3;

  // Register reset values
  localparam logic [1:0]  RST_CHANNEL_COUNT = 2'd3;
  localparam logic [23:0] RST_LEARN_BOUNDS  = 24'h0A0A0A;
  localparam logic [23:0] RST_SLACK         = 24'h141414;

  // Diff result codes
  localparam logic [7:0] MASK_BG = 8'd0;
  localparam logic [7:0] MASK_FG = 8'd255;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] pixel_index;
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
  } cbm_in_t;

  typedef struct packed {
    logic [7:0] mask_value;
    logic [3:0] entry_slot;
    logic [3:0] cleared_count;
    logic       table_full;
  } cbm_out_t;

  // Learning box and min/max range of one codeword, channel 0 in index 0
  typedef struct packed {
    logic [NUM_CH-1:0][7:0] lo;
    logic [NUM_CH-1:0][7:0] hi;
    logic [NUM_CH-1:0][7:0] mn;
    logic [NUM_CH-1:0][7:0] mx;
  } cbm_box_t;

  // Per-codeword evaluation results
  typedef struct packed {
    logic     in_box;
    logic     diff_ok;
    cbm_box_t box_upd;
    cbm_box_t box_new;
  } cbm_eval_t;

endpackage

// File: hw/rtl/cbm_pix_store.sv
// ----------------------------------------------------------------------------
// cbm_pix_store: per-pixel entry count and time memory
// Synchronous memory with registered read; zeroed by a sweep after reset.
// ----------------------------------------------------------------------------
module cbm_pix_store
  import cbm_pkg::*;
#(
  parameter int NUM_PIXELS = 4096,
  parameter int PIX_W      = 12,
  parameter int DW         = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [PIX_W-1:0] rd_addr,
  output logic [DW-1:0]    rd_data,
  input  logic             wr_en,
  input  logic [PIX_W-1:0] wr_addr,
  input  logic [DW-1:0]    wr_data,
  output logic             busy
);

  logic [DW-1:0]    mem [NUM_PIXELS];
  logic [PIX_W-1:0] sweep_r;
  logic [PIX_W-1:0] sweep_nxt;
  logic             busy_r;
  logic             busy_nxt;
  logic             we;
  logic [PIX_W-1:0] wa;
  logic [DW-1:0]    wd;

  assign busy = busy_r;

  // Advance the zeroing sweep
  always_comb begin
    sweep_nxt = sweep_r;
    busy_nxt  = busy_r;
    if (busy_r) begin
      if (sweep_r == PIX_W'(NUM_PIXELS - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        sweep_nxt = sweep_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      busy_r  <= 1'b1;
    end else begin
      sweep_r <= sweep_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // Select sweep or user write
  always_comb begin
    we = busy_r | wr_en;
    wa = busy_r ? sweep_r : wr_addr;
    wd = busy_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/cbm_cw_store.sv
// ----------------------------------------------------------------------------
// cbm_cw_store: codeword memory
// One write port and one registered read port over all codewords.
// ----------------------------------------------------------------------------
module cbm_cw_store
  import cbm_pkg::*;
#(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write and read one codeword
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/cbm_cw_eval.sv
// ----------------------------------------------------------------------------
// cbm_cw_eval: codeword compare and update logic
// Match tests, range widening, box nudging and staleness for one codeword.
// ----------------------------------------------------------------------------
module cbm_cw_eval
  import cbm_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  cbm_box_t               box,
  input  logic [TIME_BITS-1:0]   last,
  input  logic [TIME_BITS-1:0]   stale,
  input  logic [NUM_CH-1:0][7:0] pv,
  input  logic [NUM_CH-1:0]      ch_en,
  input  logic [23:0]            learn_bounds,
  input  logic [23:0]            low_slack,
  input  logic [23:0]            high_slack,
  input  logic [TIME_BITS-1:0]   t_now,
  output cbm_eval_t              res,
  output logic [TIME_BITS-1:0]   stale_new
);

  logic [NUM_CH-1:0][7:0] hil;
  logic [NUM_CH-1:0][7:0] lol;
  logic [NUM_CH-1:0][8:0] sum9;
  logic [TIME_BITS-1:0]   run;

  // Learning box around the pixel, clamped to a byte
  always_comb begin
    for (int n = 0; n < NUM_CH; n++) begin
      sum9[n] = {1'b0, pv[n]} + {1'b0, learn_bounds[8*n +: 8]};
      hil[n]  = sum9[n][8] ? 8'hFF : sum9[n][7:0];
      lol[n]  = (pv[n] > learn_bounds[8*n +: 8]) ? (pv[n] - learn_bounds[8*n +: 8]) : 8'd0;
    end
  end

  // Match tests and updated boxes
  always_comb begin
    res.in_box  = 1'b1;
    res.diff_ok = 1'b1;
    res.box_upd = box;
    for (int n = 0; n < NUM_CH; n++) begin
      res.box_new.lo[n] = lol[n];
      res.box_new.hi[n] = hil[n];
      res.box_new.mn[n] = pv[n];
      res.box_new.mx[n] = pv[n];
      if (ch_en[n]) begin
        if (!(box.lo[n] <= pv[n] && pv[n] <= box.hi[n])) begin
          res.in_box = 1'b0;
        end
        if (!(({1'b0, pv[n]} + {1'b0, low_slack[8*n +: 8]}) >= {1'b0, box.mn[n]} &&
              {1'b0, pv[n]} < ({1'b0, box.mx[n]} + {1'b0, high_slack[8*n +: 8]}))) begin
          res.diff_ok = 1'b0;
        end
        if (box.mx[n] < pv[n]) begin
          res.box_upd.mx[n] = pv[n];
        end else if (box.mn[n] > pv[n]) begin
          res.box_upd.mn[n] = pv[n];
        end
        if (box.hi[n] < hil[n]) begin
          res.box_upd.hi[n] = box.hi[n] + 8'd1;
        end
        if (box.lo[n] > lol[n]) begin
          res.box_upd.lo[n] = box.lo[n] - 8'd1;
        end
      end
    end
  end

  // Track the longest run without an update
  always_comb begin
    run       = (t_now >= last) ? (t_now - last) : '0;
    stale_new = (stale < run) ? run : stale;
  end

endmodule

// File: hw/rtl/codebook_background_model.sv
// Sequence: a taken request passes ST_PIX, an ST_SCAN step per stored codeword (cnt,
// 0 to MAX_ENTRIES), ST_END and ST_DONE; an unknown op goes straight to ST_DONE.
// Flow: one request in work at a time; ST_DONE holds the result while the output is
// stalled; the scan does one codeword read (and learn or clear write) per cycle.
// Reset is synchronous, active low; afterwards a sweep zeroes the pixel memory, during
// which no request is taken (configuration writes still are).
// ----------------------------------------------------------------------------
// codebook_background_model: per-pixel codebook background model
// Learn, clear and diff requests over codewords held in synchronous memory.
// ----------------------------------------------------------------------------
module codebook_background_model
  import cbm_pkg::*;
#(
  parameter int NUM_PIXELS   = 4096,
  parameter int MAX_ENTRIES  = 8,
  parameter int MAX_CHANNELS = 3,
  parameter int TIME_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  cbm_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cbm_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PIX_W    = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int CW_DEPTH = NUM_PIXELS * MAX_ENTRIES;
  localparam int CW_AW    = (CW_DEPTH > 1) ? $clog2(CW_DEPTH) : 1;
  localparam int PX_DW    = CNT_W + TIME_BITS;
  localparam int CW_DW    = $bits(cbm_box_t) + 2 * TIME_BITS;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PIX  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_END  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // Configuration registers
  logic [1:0]  cc_r;
  logic [23:0] lb_r;
  logic [23:0] ls_r;
  logic [23:0] hs_r;
  logic        cfg_wr;

  // Sequencer state
  logic [2:0]             state_r, state_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [PIX_W-1:0]       pix_r, pix_nxt;
  logic [NUM_CH-1:0][7:0] pv_r, pv_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0]   time_r, time_nxt;
  logic [TIME_BITS-1:0]   t_r, t_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       keep_r, keep_nxt;
  logic [CNT_W-1:0]       slot_r, slot_nxt;
  logic                   found_r, found_nxt;
  logic                   hit_r, hit_nxt;
  cbm_out_t               res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  cbm_out_t               out_data_r, out_data_nxt;

  // Memory ports
  logic                 px_re, px_we, px_busy;
  logic [PIX_W-1:0]     px_raddr;
  logic [PX_DW-1:0]     px_rdata, px_wdata;
  logic [CNT_W-1:0]     px_rd_cnt;
  logic [TIME_BITS-1:0] px_rd_time;
  logic                 cw_we, cw_re;
  logic [CW_AW-1:0]     cw_waddr, cw_raddr, cw_base;
  logic [CW_DW-1:0]     cw_wdata, cw_rdata;
  cbm_box_t             rd_box;
  logic [TIME_BITS-1:0] rd_last, rd_stale, stale_new;
  cbm_eval_t            ev;

  logic                 in_acc;
  logic                 out_free;
  logic [31:0]          in_pix_ext;
  logic                 pix_ok;
  logic [1:0]           nch;
  logic [NUM_CH-1:0]    ch_en;
  logic [CNT_W-1:0]     idx_p1;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= RST_CHANNEL_COUNT;
      lb_r <= RST_LEARN_BOUNDS;
      ls_r <= RST_SLACK;
      hs_r <= RST_SLACK;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CHANNEL_COUNT: cc_r <= pwdata[1:0];
        REG_LEARN_BOUNDS:  lb_r <= pwdata[23:0];
        REG_LOW_SLACK:     ls_r <= pwdata[23:0];
        REG_HIGH_SLACK:    hs_r <= pwdata[23:0];
        default:           cc_r <= cc_r;
      endcase
    end
  end

  // Read back a register
  always_comb begin
    unique case (paddr[3:2])
      REG_CHANNEL_COUNT: prdata = {30'd0, cc_r};
      REG_LEARN_BOUNDS:  prdata = {8'd0, lb_r};
      REG_LOW_SLACK:     prdata = {8'd0, ls_r};
      REG_HIGH_SLACK:    prdata = {8'd0, hs_r};
      default:           prdata = '0;
    endcase
  end

  // Clamp the channel count and build the channel enables
  always_comb begin
    nch = (cc_r == 2'd0) ? 2'd1 : cc_r;
    if (32'(nch) > MAX_CHANNELS) begin
      nch = 2'(MAX_CHANNELS);
    end
    for (int n = 0; n < NUM_CH; n++) begin
      ch_en[n] = (n < 32'(nch));
    end
  end

  // ---------------------------------------------------------------- memories
  cbm_pix_store #(
    .NUM_PIXELS (NUM_PIXELS),
    .PIX_W      (PIX_W),
    .DW         (PX_DW)
  ) u_pix_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (px_re),
    .rd_addr (px_raddr),
    .rd_data (px_rdata),
    .wr_en   (px_we),
    .wr_addr (pix_r),
    .wr_data (px_wdata),
    .busy    (px_busy)
  );

  cbm_cw_store #(
    .DEPTH (CW_DEPTH),
    .AW    (CW_AW),
    .DW    (CW_DW)
  ) u_cw_store (
    .clk   (clk),
    .we    (cw_we),
    .waddr (cw_waddr),
    .wdata (cw_wdata),
    .re    (cw_re),
    .raddr (cw_raddr),
    .rdata (cw_rdata)
  );

  assign {px_rd_cnt, px_rd_time} = px_rdata;
  assign {rd_box, rd_last, rd_stale} = cw_rdata;

  cbm_cw_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_cw_eval (
    .box          (rd_box),
    .last         (rd_last),
    .stale        (rd_stale),
    .pv           (pv_r),
    .ch_en        (ch_en),
    .learn_bounds (lb_r),
    .low_slack    (ls_r),
    .high_slack   (hs_r),
    .t_now        (t_r),
    .res          (ev),
    .stale_new    (stale_new)
  );

  // ---------------------------------------------------------------- handshake
  assign in_stall  = (state_r != ST_IDLE) | px_busy;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = ~out_valid_r | ~out_stall;

  assign in_pix_ext = {20'd0, in_data.pixel_index};
  assign pix_ok     = in_pix_ext < 32'(NUM_PIXELS);
  assign cw_base    = CW_AW'(pix_r) * CW_AW'(MAX_ENTRIES);
  assign idx_p1     = idx_r + 1'b1;
  assign px_re      = in_acc;
  assign px_raddr   = in_pix_ext[PIX_W-1:0];

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pix_nxt       = pix_r;
    pv_nxt        = pv_r;
    cnt_nxt       = cnt_r;
    time_nxt      = time_r;
    t_nxt         = t_r;
    idx_nxt       = idx_r;
    keep_nxt      = keep_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    px_we         = 1'b0;
    px_wdata      = '0;
    cw_we         = 1'b0;
    cw_waddr      = cw_base;
    cw_wdata      = '0;
    cw_re         = 1'b0;
    cw_raddr      = cw_base;

    unique case (state_r)
      ST_IDLE: begin
        // Latch the request and start the pixel read
        if (in_acc) begin
          op_nxt  = in_data.op;
          pix_nxt = in_pix_ext[PIX_W-1:0];
          pv_nxt  = {in_data.chan2, in_data.chan1, in_data.chan0};
          res_nxt = '0;
          if (pix_ok && (in_data.op == OP_LEARN || in_data.op == OP_CLEAR ||
                         in_data.op == OP_DIFF)) begin
            state_nxt = ST_PIX;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_PIX: begin
        // Take count and time, start the codeword scan
        cnt_nxt   = px_rd_cnt;
        time_nxt  = px_rd_time;
        t_nxt     = (px_rd_time < TIME_MAX) ? (px_rd_time + 1'b1) : px_rd_time;
        idx_nxt   = '0;
        keep_nxt  = '0;
        slot_nxt  = '0;
        found_nxt = 1'b0;
        hit_nxt   = 1'b0;
        if (px_rd_cnt == '0) begin
          state_nxt = ST_END;
        end else begin
          cw_re     = 1'b1;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Modify and write back the codeword at idx_r (clear writes kept ones at keep_r, diff only tests it)
        unique case (op_r)
          OP_LEARN: begin
            cw_we    = 1'b1;
            cw_waddr = cw_base + CW_AW'(idx_r);
            if (!found_r && ev.in_box) begin
              found_nxt = 1'b1;
              slot_nxt  = idx_r;
              cw_wdata  = {ev.box_upd, t_r, rd_stale};
            end else begin
              cw_wdata  = {rd_box, rd_last, stale_new};
            end
          end
          OP_CLEAR: begin
            if (rd_stale <= (time_r >> 1)) begin
              cw_we    = 1'b1;
              cw_waddr = cw_base + CW_AW'(keep_r);
              cw_wdata = {rd_box, {TIME_BITS{1'b0}}, rd_stale};
              keep_nxt = keep_r + 1'b1;
            end
          end
          default: begin
            if (ev.diff_ok) begin
              hit_nxt = 1'b1;
            end
          end
        endcase
        // Advance to the next codeword
        if (idx_p1 == cnt_r) begin
          state_nxt = ST_END;
        end else begin
          idx_nxt  = idx_p1;
          cw_re    = 1'b1;
          cw_raddr = cw_base + CW_AW'(idx_p1);
        end
      end

      ST_END: begin
        // Append a codeword if needed, write back the pixel, form the result
        px_we = 1'b1;
        unique case (op_r)
          OP_LEARN: begin
            px_wdata = {cnt_r, t_r};
            if (found_r) begin
              res_nxt.entry_slot = 4'(slot_r);
            end else if (cnt_r >= CNT_W'(MAX_ENTRIES)) begin
              res_nxt.entry_slot = 4'(MAX_ENTRIES);
              res_nxt.table_full = 1'b1;
            end else begin
              cw_we              = 1'b1;
              cw_waddr           = cw_base + CW_AW'(cnt_r);
              cw_wdata           = {ev.box_new, t_r, {TIME_BITS{1'b0}}};
              px_wdata           = {cnt_r + 1'b1, t_r};
              res_nxt.entry_slot = 4'(cnt_r);
            end
          end
          OP_CLEAR: begin
            px_wdata              = {keep_r, {TIME_BITS{1'b0}}};
            res_nxt.cleared_count = 4'(cnt_r - keep_r);
          end
          default: begin
            px_wdata           = {cnt_r, time_r};
            res_nxt.mask_value = hit_r ? MASK_BG : MASK_FG;
          end
        endcase
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // Hand the result to the output register
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      hit_r       <= 1'b0;
      idx_r       <= '0;
      keep_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      hit_r       <= hit_nxt;
      idx_r       <= idx_nxt;
      keep_r      <= keep_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pix_r      <= pix_nxt;
    pv_r       <= pv_nxt;
    time_r     <= time_nxt;
    t_r        <= t_nxt;
    slot_r     <= slot_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_scan_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r < cnt_r)
    else $error("codeword scan index past entry count");

  a_keep_le_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> keep_r <= idx_r)
    else $error("compaction target ahead of scan index");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    px_we |-> px_wdata[PX_DW-1:TIME_BITS] <= CNT_W'(MAX_ENTRIES))
    else $error("pixel entry count above table size");

  a_no_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    px_busy |-> in_stall)
    else $error("request accepted during pixel memory sweep");
`endif

endmodule

// File: sim/cbm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cbm_checker: request/result scoreboard for the codebook background model
// Watches the configuration port and both channels, runs its own copy of the
// per-pixel codebooks and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module cbm_checker
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  cbm_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  cbm_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  localparam int PIXELS  = 4096;
  localparam int ENTRIES = 8;
  localparam int TMAX    = 65535;

  // Shadow copy of the registers
  logic [1:0]  chan_cfg;
  logic [23:0] learn_cfg;
  logic [23:0] lo_slack_cfg;
  logic [23:0] hi_slack_cfg;

  // Shadow copy of the codebooks
  int unsigned cw_count [PIXELS];
  int unsigned pix_time [PIXELS];
  logic [7:0]  box_lo   [PIXELS*ENTRIES][3];
  logic [7:0]  box_hi   [PIXELS*ENTRIES][3];
  logic [7:0]  rng_min  [PIXELS*ENTRIES][3];
  logic [7:0]  rng_max  [PIXELS*ENTRIES][3];
  int unsigned t_last   [PIXELS*ENTRIES];
  int unsigned t_stale  [PIXELS*ENTRIES];

  cbm_out_t expected_results[$];

  initial begin
    for (int p = 0; p < PIXELS; p++) begin
      cw_count[p] = 0;
      pix_time[p] = 0;
    end
  end

  function automatic int unsigned used_channels();
    if (chan_cfg == 2'd0) return 1;
    return chan_cfg;
  endfunction

  // Learn: advance time, match or append a codeword, age, nudge box
  function automatic cbm_out_t learn_pixel(int unsigned pix, int unsigned v[3]);
    cbm_out_t    r;
    int unsigned nch, base, cnt, t, hit, e, run, b;
    int unsigned hi[3], lo[3];
    bit          ok;
    r = '0;
    nch = used_channels();
    base = pix * ENTRIES;
    cnt = cw_count[pix];
    if (pix_time[pix] < TMAX) pix_time[pix]++;
    t = pix_time[pix];
    for (int n = 0; n < 3; n++) begin
      b = learn_cfg[8*n +: 8];
      hi[n] = (v[n] + b > 255) ? 255 : v[n] + b;
      lo[n] = (v[n] > b) ? v[n] - b : 0;
    end
    hit = cnt;
    for (int i = 0; i < cnt; i++) begin
      if (hit == cnt) begin
        e = base + i;
        ok = 1;
        for (int n = 0; n < nch; n++)
          if (!(box_lo[e][n] <= v[n] && v[n] <= box_hi[e][n])) ok = 0;
        if (ok) begin
          hit = i;
          t_last[e] = t;
          for (int n = 0; n < nch; n++) begin
            if (rng_max[e][n] < v[n]) rng_max[e][n] = 8'(v[n]);
            else if (rng_min[e][n] > v[n]) rng_min[e][n] = 8'(v[n]);
          end
        end
      end
    end
    for (int s = 0; s < cnt; s++) begin
      e = base + s;
      run = (t >= t_last[e]) ? t - t_last[e] : 0;
      if (t_stale[e] < run) t_stale[e] = run;
    end
    if (hit == cnt) begin
      if (cnt >= ENTRIES) begin
        r.entry_slot = 4'(ENTRIES);
        r.table_full = 1'b1;
        return r;
      end
      e = base + cnt;
      for (int n = 0; n < 3; n++) begin
        box_hi[e][n] = 8'(hi[n]);
        box_lo[e][n] = 8'(lo[n]);
        rng_max[e][n] = 8'(v[n]);
        rng_min[e][n] = 8'(v[n]);
      end
      t_last[e] = t;
      t_stale[e] = 0;
      cw_count[pix] = cnt + 1;
    end
    e = base + hit;
    for (int n = 0; n < nch; n++) begin
      if (box_hi[e][n] < hi[n]) box_hi[e][n] = box_hi[e][n] + 8'd1;
      if (box_lo[e][n] > lo[n]) box_lo[e][n] = box_lo[e][n] - 8'd1;
    end
    r.entry_slot = 4'(hit);
    return r;
  endfunction

  // Clear: drop stale codewords, compact the rest, restart the time
  function automatic cbm_out_t clear_pixel(int unsigned pix);
    cbm_out_t    r;
    int unsigned base, cnt, thresh, k, src, dst;
    r = '0;
    base = pix * ENTRIES;
    cnt = cw_count[pix];
    thresh = pix_time[pix] >> 1;
    k = 0;
    for (int i = 0; i < cnt; i++) begin
      src = base + i;
      if (t_stale[src] <= thresh) begin
        dst = base + k;
        if (k != i) begin
          box_lo[dst] = box_lo[src];
          box_hi[dst] = box_hi[src];
          rng_min[dst] = rng_min[src];
          rng_max[dst] = rng_max[src];
          t_stale[dst] = t_stale[src];
        end
        t_last[dst] = 0;
        k++;
      end
    end
    pix_time[pix] = 0;
    cw_count[pix] = k;
    r.cleared_count = 4'(cnt - k);
    return r;
  endfunction

  // Diff: background when some widened min/max box holds the pixel
  function automatic cbm_out_t diff_pixel(int unsigned pix, int unsigned v[3]);
    cbm_out_t r;
    int       lo, hi, e;
    bit       ok;
    r = '0;
    r.mask_value = MASK_FG;
    for (int i = 0; i < cw_count[pix]; i++) begin
      e = pix * ENTRIES + i;
      ok = 1;
      for (int n = 0; n < used_channels(); n++) begin
        lo = int'(rng_min[e][n]) - int'(lo_slack_cfg[8*n +: 8]);
        hi = int'(rng_max[e][n]) + int'(hi_slack_cfg[8*n +: 8]);
        if (!(lo <= int'(v[n]) && int'(v[n]) < hi)) ok = 0;
      end
      if (ok) r.mask_value = MASK_BG;
    end
    return r;
  endfunction

  function automatic cbm_out_t predict_result(cbm_in_t req);
    int unsigned v[3];
    v[0] = req.chan0;
    v[1] = req.chan1;
    v[2] = req.chan2;
    case (req.op)
      OP_LEARN: return learn_pixel(req.pixel_index, v);
      OP_CLEAR: return clear_pixel(req.pixel_index);
      OP_DIFF:  return diff_pixel(req.pixel_index, v);
      default:  return '0;
    endcase
  endfunction

  // Track registers, predict accepted requests, compare accepted results
  always @(posedge clk) begin
    cbm_out_t exp_r;
    if (!rst_n) begin
      chan_cfg     = RST_CHANNEL_COUNT;
      learn_cfg    = RST_LEARN_BOUNDS;
      lo_slack_cfg = RST_SLACK;
      hi_slack_cfg = RST_SLACK;
      errors       = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CHANNEL_COUNT: chan_cfg     = pwdata[1:0];
          REG_LEARN_BOUNDS:  learn_cfg    = pwdata[23:0];
          REG_LOW_SLACK:     lo_slack_cfg = pwdata[23:0];
          REG_HIGH_SLACK:    hi_slack_cfg = pwdata[23:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_result(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data.mask_value !== exp_r.mask_value) begin
            $display("%0t: mask_value expected %0d actual %0d", $time,
                     exp_r.mask_value, out_data.mask_value);
            errors++;
          end
          if (out_data.entry_slot !== exp_r.entry_slot) begin
            $display("%0t: entry_slot expected %0d actual %0d", $time,
                     exp_r.entry_slot, out_data.entry_slot);
            errors++;
          end
          if (out_data.cleared_count !== exp_r.cleared_count) begin
            $display("%0t: cleared_count expected %0d actual %0d", $time,
                     exp_r.cleared_count, out_data.cleared_count);
            errors++;
          end
          if (out_data.table_full !== exp_r.table_full) begin
            $display("%0t: table_full expected %0d actual %0d", $time,
                     exp_r.table_full, out_data.table_full);
            errors++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: sim/tb_codebook_background_model.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_codebook_background_model: stimulus and verdict for the codebook model
// Drives directed and clustered random learn/clear/diff requests over a few
// register settings with random idling on both sides; the checker compares.
// ----------------------------------------------------------------------------
module tb_codebook_background_model;
  import cbm_pkg::*;

  localparam int POOL      = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN     = 20;

  // Op code with no defined action
  localparam logic [1:0] OP_NONE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  cbm_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  cbm_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;

  int          snd_idle;
  int          rcv_idle;
  logic        hold_go;
  logic        hold_seen;
  int          hold_left;
  int          quiet_cycles;

  logic [11:0] pix_pool [POOL];
  logic [7:0]  centers  [POOL][3][3];

  codebook_background_model dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cbm_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    snd_idle = 19;
    rcv_idle = 57;
    hold_go = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
  end

  always #10 clk = ~clk;

  // Receiver: random stall, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1) || ($urandom_range(99) < rcv_idle);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end
  initial quiet_cycles = 0;

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one request, idling first at random, and hold it until taken
  task automatic send_req(logic [1:0] op, logic [11:0] pix,
                          logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    cbm_in_t r;
    r.op = op;
    r.pixel_index = pix;
    r.chan0 = c0;
    r.chan1 = c1;
    r.chan2 = c2;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      in_data <= '0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [7:0] jitter(logic [7:0] c);
    int v;
    v = int'(c) + $urandom_range(12) - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Clustered random requests over a fresh set of pixels
  task automatic random_phase(int count);
    int k, slot, pick;
    logic [1:0] op;
    logic [7:0] c[3];
    for (int p = 0; p < POOL; p++) begin
      pix_pool[p] = 12'($urandom_range(4095));
      for (int m = 0; m < 3; m++)
        for (int n = 0; n < 3; n++) centers[p][m][n] = 8'($urandom_range(255));
    end
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 60) op = OP_LEARN;
      else if (pick < 90) op = OP_DIFF;
      else if (pick < 97) op = OP_CLEAR;
      else op = OP_NONE;
      slot = $urandom_range(POOL - 1);
      pick = $urandom_range(2);
      for (int n = 0; n < 3; n++)
        c[n] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                        : jitter(centers[slot][pick][n]);
      send_req(op, pix_pool[slot], c[0], c[1], c[2]);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: append, match, diff hit and miss, empty table, unknown op
    send_req(OP_LEARN, 12'd0, 8'd100, 8'd100, 8'd100);
    send_req(OP_LEARN, 12'd0, 8'd104, 8'd97, 8'd100);
    send_req(OP_DIFF, 12'd0, 8'd102, 8'd99, 8'd100);
    send_req(OP_DIFF, 12'd0, 8'd200, 8'd10, 8'd100);
    send_req(OP_DIFF, 12'd4095, 8'd0, 8'd0, 8'd0);
    send_req(OP_NONE, 12'd0, 8'd255, 8'd255, 8'd255);
    // Clamp at both ends of the byte range
    send_req(OP_LEARN, 12'd4095, 8'd255, 8'd255, 8'd255);
    send_req(OP_LEARN, 12'd4095, 8'd0, 8'd0, 8'd0);
    send_req(OP_DIFF, 12'd4095, 8'd255, 8'd0, 8'd255);
    // Fill one table and overflow it
    for (int i = 0; i < 9; i++)
      send_req(OP_LEARN, 12'd1, 8'(30 * i), 8'(30 * i), 8'(30 * i));
    send_req(OP_LEARN, 12'd0, 8'd100, 8'd100, 8'd100);
    send_req(OP_CLEAR, 12'd0, 8'd0, 8'd0, 8'd0);
    send_req(OP_CLEAR, 12'd1, 8'd0, 8'd0, 8'd0);
    send_req(OP_CLEAR, 12'd2, 8'd0, 8'd0, 8'd0);
    drain();

    // Sender idles less, receiver more
    snd_idle = 19;
    rcv_idle = 57;
    cfg_write(REG_CHANNEL_COUNT, 32'd3);
    cfg_write(REG_LEARN_BOUNDS, 32'h0C0806);
    cfg_write(REG_LOW_SLACK, 32'h0A141E);
    cfg_write(REG_HIGH_SLACK, 32'h1E140A);
    random_phase(500);
    drain();

    // The other way round, single channel and zero widths
    snd_idle = 57;
    rcv_idle = 19;
    cfg_write(REG_CHANNEL_COUNT, 32'd0);
    cfg_write(REG_LEARN_BOUNDS, 32'h000000);
    cfg_write(REG_LOW_SLACK, 32'h000000);
    cfg_write(REG_HIGH_SLACK, 32'h000000);
    random_phase(250);
    drain();
    cfg_write(REG_CHANNEL_COUNT, 32'd1);
    cfg_write(REG_LEARN_BOUNDS, 32'h030303);
    cfg_write(REG_HIGH_SLACK, 32'h050505);
    random_phase(250);
    drain();

    // No idling, widest settings, with one long receiver hold-off
    snd_idle = 0;
    rcv_idle = 0;
    cfg_write(REG_CHANNEL_COUNT, 32'd2);
    cfg_write(REG_LEARN_BOUNDS, 32'hFFFFFF);
    cfg_write(REG_LOW_SLACK, 32'hFFFFFF);
    cfg_write(REG_HIGH_SLACK, 32'hFFFFFF);
    hold_go <= 1'b1;
    random_phase(250);
    drain();
    cfg_write(REG_CHANNEL_COUNT, 32'd3);
    cfg_write(REG_LEARN_BOUNDS, 32'h0A0A0A);
    cfg_write(REG_LOW_SLACK, 32'h141414);
    cfg_write(REG_HIGH_SLACK, 32'h141414);
    random_phase(260);

    // Let one codeword of a pixel go stale, then clear it
    send_req(OP_LEARN, 12'd3, 8'd50, 8'd60, 8'd70);
    send_req(OP_LEARN, 12'd3, 8'd150, 8'd160, 8'd170);
    for (int i = 0; i < 20; i++)
      send_req(OP_LEARN, 12'd3, 8'd50, 8'd60, 8'd70);
    send_req(OP_DIFF, 12'd3, 8'd150, 8'd160, 8'd170);
    send_req(OP_CLEAR, 12'd3, 8'd0, 8'd0, 8'd0);
    send_req(OP_LEARN, 12'd3, 8'd50, 8'd60, 8'd70);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_pix_store.sv
hw/rtl/cbm_cw_store.sv
hw/rtl/cbm_cw_eval.sv
hw/rtl/codebook_background_model.sv
sim/cbm_checker.sv
sim/tb_codebook_background_model.sv
